### hdl/icsb_pkg.sv
// icsb_pkg: shared types, constants and the microcode program of the
// indexed char sequence buffer. No dependencies.
package icsb_pkg;

    localparam int CAPACITY = 64;

    localparam int CMD_W   = 4;
    localparam int VAL_W   = 8;
    localparam int POS_W   = 7;
    localparam int COUNT_W = 7;
    localparam int STAT_W  = 2;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int PTR_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int EXT_W = PTR_W + 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT   = 4'd0,
        CMD_PUSH_BACK    = 4'd1,
        CMD_INSERT_AT    = 4'd2,
        CMD_INSERT_SORT  = 4'd3,
        CMD_POP_FRONT    = 4'd4,
        CMD_POP_BACK     = 4'd5,
        CMD_REMOVE_AT    = 4'd6,
        CMD_REPLACE_AT   = 4'd7,
        CMD_READ_AT      = 4'd8,
        CMD_FIRST        = 4'd9,
        CMD_LAST         = 4'd10,
        CMD_FIND         = 4'd11,
        CMD_CLEAR        = 4'd12
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef struct packed {
        t_cmd                     command;
        logic signed [VAL_W-1:0]  value;
        logic [POS_W-1:0]         position;
    } t_req;

    typedef struct packed {
        logic signed [VAL_W-1:0]  data;
        logic                     found;
        logic [COUNT_W-1:0]       count;
        t_status                  status;
    } t_res;

    // datapath operations, one per control word
    typedef enum logic [4:0] {
        OP_NOP,
        OP_EMIT,
        OP_SET_RANGE,
        OP_SET_EMPTY,
        OP_SET_FULL,
        OP_POS_ZERO,
        OP_POS_CNT,
        OP_POS_LAST,
        OP_IDX_CNT,
        OP_SHIFT_UP,
        OP_WR_VAL_INC,
        OP_IDX_POS,
        OP_SHIFT_DN,
        OP_DEC_CNT,
        OP_WR_POS,
        OP_RD_POS,
        OP_LATCH,
        OP_SCAN_START,
        OP_SCAN_SORT,
        OP_SCAN_FIND,
        OP_CLEAR
    } t_uop;

    // jump conditions
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_EMPTY,
        C_FULL,
        C_POS_GT_CNT,
        C_POS_GE_CNT,
        C_CNT_LE_POS,
        C_UP_MORE,
        C_NO_DN,
        C_DN_MORE,
        C_SORT_MORE,
        C_FIND_MORE
    } t_ucond;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } t_seq_state;

    localparam int UADDR_W = 6;
    typedef logic [UADDR_W-1:0] t_uaddr;

    typedef struct packed {
        t_uop    op;
        t_ucond  cond;
        t_uaddr  target;
    } t_uword;

    typedef struct packed {
        logic empty;
        logic full;
        logic pos_gt_cnt;
        logic pos_ge_cnt;
        logic cnt_le_pos;
        logic up_more;
        logic no_dn;
        logic dn_more;
        logic sort_more;
        logic find_more;
    } t_flags;

    typedef struct packed {
        logic  load;
        t_uop  op;
    } t_dp_ctrl;

    // microprogram addresses
    localparam t_uaddr UA_EMIT       = 6'd0;
    localparam t_uaddr UA_ERR_RANGE  = 6'd1;
    localparam t_uaddr UA_ERR_EMPTY  = 6'd2;
    localparam t_uaddr UA_ERR_FULL   = 6'd3;
    localparam t_uaddr UA_PUSH_F     = 6'd4;
    localparam t_uaddr UA_FULL_CHK   = 6'd5;
    localparam t_uaddr UA_INS        = 6'd6;
    localparam t_uaddr UA_INS_SHIFT  = 6'd7;
    localparam t_uaddr UA_INS_PUT    = 6'd8;
    localparam t_uaddr UA_PUSH_B     = 6'd9;
    localparam t_uaddr UA_INS_AT     = 6'd10;
    localparam t_uaddr UA_INS_AT_GO  = 6'd11;
    localparam t_uaddr UA_SORT       = 6'd12;
    localparam t_uaddr UA_SORT_START = 6'd13;
    localparam t_uaddr UA_SORT_SCAN  = 6'd14;
    localparam t_uaddr UA_SORT_GO    = 6'd15;
    localparam t_uaddr UA_POP_F      = 6'd16;
    localparam t_uaddr UA_REM        = 6'd17;
    localparam t_uaddr UA_REM_SHIFT  = 6'd18;
    localparam t_uaddr UA_REM_DEC    = 6'd19;
    localparam t_uaddr UA_POP_B      = 6'd20;
    localparam t_uaddr UA_POP_B_GO   = 6'd21;
    localparam t_uaddr UA_REM_AT     = 6'd22;
    localparam t_uaddr UA_REM_AT_GO  = 6'd23;
    localparam t_uaddr UA_REPL       = 6'd24;
    localparam t_uaddr UA_REPL_PUT   = 6'd25;
    localparam t_uaddr UA_RD_AT      = 6'd26;
    localparam t_uaddr UA_RD_LATCH   = 6'd27;
    localparam t_uaddr UA_FIRST      = 6'd28;
    localparam t_uaddr UA_FIRST_GO   = 6'd29;
    localparam t_uaddr UA_LAST       = 6'd30;
    localparam t_uaddr UA_LAST_GO    = 6'd31;
    localparam t_uaddr UA_FIND       = 6'd32;
    localparam t_uaddr UA_FIND_SCAN  = 6'd33;
    localparam t_uaddr UA_FIND_END   = 6'd34;
    localparam t_uaddr UA_CLEAR      = 6'd35;

    function automatic t_uword uw(input t_uop op, input t_ucond cond, input t_uaddr target);
        t_uword w;
        w.op     = op;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    // control store: jump to target when cond holds, else fall through
    function automatic t_uword ucode_rom(input t_uaddr a);
        t_uword w;
        case (a)
            UA_EMIT:       w = uw(OP_EMIT,       C_NEVER,      UA_EMIT);
            UA_ERR_RANGE:  w = uw(OP_SET_RANGE,  C_ALWAYS,     UA_EMIT);
            UA_ERR_EMPTY:  w = uw(OP_SET_EMPTY,  C_ALWAYS,     UA_EMIT);
            UA_ERR_FULL:   w = uw(OP_SET_FULL,   C_ALWAYS,     UA_EMIT);
            UA_PUSH_F:     w = uw(OP_POS_ZERO,   C_NEVER,      UA_EMIT);
            UA_FULL_CHK:   w = uw(OP_NOP,        C_FULL,       UA_ERR_FULL);
            UA_INS:        w = uw(OP_IDX_CNT,    C_CNT_LE_POS, UA_INS_PUT);
            UA_INS_SHIFT:  w = uw(OP_SHIFT_UP,   C_UP_MORE,    UA_INS_SHIFT);
            UA_INS_PUT:    w = uw(OP_WR_VAL_INC, C_ALWAYS,     UA_EMIT);
            UA_PUSH_B:     w = uw(OP_POS_CNT,    C_ALWAYS,     UA_FULL_CHK);
            UA_INS_AT:     w = uw(OP_NOP,        C_POS_GT_CNT, UA_ERR_RANGE);
            UA_INS_AT_GO:  w = uw(OP_NOP,        C_ALWAYS,     UA_FULL_CHK);
            UA_SORT:       w = uw(OP_NOP,        C_FULL,       UA_ERR_FULL);
            UA_SORT_START: w = uw(OP_SCAN_START, C_EMPTY,      UA_INS);
            UA_SORT_SCAN:  w = uw(OP_SCAN_SORT,  C_SORT_MORE,  UA_SORT_SCAN);
            UA_SORT_GO:    w = uw(OP_NOP,        C_ALWAYS,     UA_INS);
            UA_POP_F:      w = uw(OP_POS_ZERO,   C_EMPTY,      UA_ERR_EMPTY);
            UA_REM:        w = uw(OP_IDX_POS,    C_NO_DN,      UA_REM_DEC);
            UA_REM_SHIFT:  w = uw(OP_SHIFT_DN,   C_DN_MORE,    UA_REM_SHIFT);
            UA_REM_DEC:    w = uw(OP_DEC_CNT,    C_ALWAYS,     UA_EMIT);
            UA_POP_B:      w = uw(OP_NOP,        C_EMPTY,      UA_ERR_EMPTY);
            UA_POP_B_GO:   w = uw(OP_NOP,        C_ALWAYS,     UA_REM_DEC);
            UA_REM_AT:     w = uw(OP_NOP,        C_POS_GE_CNT, UA_ERR_RANGE);
            UA_REM_AT_GO:  w = uw(OP_NOP,        C_ALWAYS,     UA_REM);
            UA_REPL:       w = uw(OP_NOP,        C_POS_GE_CNT, UA_ERR_RANGE);
            UA_REPL_PUT:   w = uw(OP_WR_POS,     C_ALWAYS,     UA_EMIT);
            UA_RD_AT:      w = uw(OP_RD_POS,     C_POS_GE_CNT, UA_ERR_RANGE);
            UA_RD_LATCH:   w = uw(OP_LATCH,      C_ALWAYS,     UA_EMIT);
            UA_FIRST:      w = uw(OP_POS_ZERO,   C_EMPTY,      UA_ERR_EMPTY);
            UA_FIRST_GO:   w = uw(OP_RD_POS,     C_ALWAYS,     UA_RD_LATCH);
            UA_LAST:       w = uw(OP_POS_LAST,   C_EMPTY,      UA_ERR_EMPTY);
            UA_LAST_GO:    w = uw(OP_RD_POS,     C_ALWAYS,     UA_RD_LATCH);
            UA_FIND:       w = uw(OP_SCAN_START, C_EMPTY,      UA_EMIT);
            UA_FIND_SCAN:  w = uw(OP_SCAN_FIND,  C_FIND_MORE,  UA_FIND_SCAN);
            UA_FIND_END:   w = uw(OP_NOP,        C_ALWAYS,     UA_EMIT);
            UA_CLEAR:      w = uw(OP_CLEAR,      C_ALWAYS,     UA_EMIT);
            default:       w = uw(OP_EMIT,       C_NEVER,      UA_EMIT);
        endcase
        return w;
    endfunction

    // dispatch table: first control word of each command
    function automatic t_uaddr entry_of(input t_cmd c);
        t_uaddr a;
        case (c)
            CMD_PUSH_FRONT:  a = UA_PUSH_F;
            CMD_PUSH_BACK:   a = UA_PUSH_B;
            CMD_INSERT_AT:   a = UA_INS_AT;
            CMD_INSERT_SORT: a = UA_SORT;
            CMD_POP_FRONT:   a = UA_POP_F;
            CMD_POP_BACK:    a = UA_POP_B;
            CMD_REMOVE_AT:   a = UA_REM_AT;
            CMD_REPLACE_AT:  a = UA_REPL;
            CMD_READ_AT:     a = UA_RD_AT;
            CMD_FIRST:       a = UA_FIRST;
            CMD_LAST:        a = UA_LAST;
            CMD_FIND:        a = UA_FIND;
            CMD_CLEAR:       a = UA_CLEAR;
            default:         a = UA_EMIT;
        endcase
        return a;
    endfunction

endpackage

### hdl/icsb_ram.sv
// icsb_ram: generic single-write, single-read memory with registered read data.
// No dependencies.
module icsb_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/icsb_seq.sv
// icsb_seq: step counter, control store fetch and jump logic.
// Depends on icsb_pkg.
module icsb_seq import icsb_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req_valid,
    input  t_cmd     i_cmd,
    input  t_flags   i_flags,
    input  logic     i_out_free,
    output logic     o_busy,
    output t_dp_ctrl o_ctrl,
    output logic     o_emit
);

    t_seq_state r_state, n_state;
    t_uaddr     r_upc, n_upc;
    t_uword     w;
    logic       take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_IDLE;
            r_upc   <= UA_EMIT;
        end else begin
            r_state <= n_state;
            r_upc   <= n_upc;
        end
    end

    always_comb begin
        w = ucode_rom(r_upc);

        case (w.cond)
            C_NEVER:      take = 1'b0;
            C_ALWAYS:     take = 1'b1;
            C_EMPTY:      take = i_flags.empty;
            C_FULL:       take = i_flags.full;
            C_POS_GT_CNT: take = i_flags.pos_gt_cnt;
            C_POS_GE_CNT: take = i_flags.pos_ge_cnt;
            C_CNT_LE_POS: take = i_flags.cnt_le_pos;
            C_UP_MORE:    take = i_flags.up_more;
            C_NO_DN:      take = i_flags.no_dn;
            C_DN_MORE:    take = i_flags.dn_more;
            C_SORT_MORE:  take = i_flags.sort_more;
            C_FIND_MORE:  take = i_flags.find_more;
            default:      take = 1'b0;
        endcase

        n_state     = r_state;
        n_upc       = r_upc;
        o_ctrl.load = 1'b0;
        o_ctrl.op   = OP_NOP;
        o_emit      = 1'b0;

        case (r_state)
            SEQ_IDLE: begin
                if (i_req_valid) begin
                    o_ctrl.load = 1'b1;
                    n_state     = SEQ_RUN;
                    n_upc       = entry_of(i_cmd);
                end
            end
            SEQ_RUN: begin
                o_ctrl.op = w.op;
                if (w.op == OP_EMIT) begin
                    // hold here until the result register is free
                    if (i_out_free) begin
                        o_emit  = 1'b1;
                        n_state = SEQ_IDLE;
                    end
                end else begin
                    n_upc = take ? w.target : r_upc + t_uaddr'(1);
                end
            end
            default: begin
                n_state = SEQ_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != SEQ_IDLE);

endmodule

### hdl/icsb_dp.sv
// icsb_dp: element store, count, index and result registers driven by control words.
// Depends on icsb_pkg and icsb_ram.
module icsb_dp import icsb_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_dp_ctrl i_ctrl,
    input  t_req     i_req,
    output t_flags   o_flags,
    output t_res     o_res
);

    logic signed [VAL_W-1:0] r_val, n_val;
    logic [PTR_W-1:0]        r_pos, n_pos;
    logic [PTR_W-1:0]        r_idx, n_idx;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic signed [VAL_W-1:0] r_data, n_data;
    logic                    r_found, n_found;
    t_status                 r_status, n_status;

    logic                    we;
    logic [EXT_W-1:0]        waddr_x, raddr_x;
    logic signed [VAL_W-1:0] wdata;
    logic signed [VAL_W-1:0] rdata;

    logic [EXT_W-1:0] pos_x, idx_x, cnt_x;
    logic             sort_hit, idx_next_lt;

    icsb_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (VAL_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr_x[IDX_W-1:0]),
        .i_wdata (wdata),
        .i_raddr (raddr_x[IDX_W-1:0]),
        .o_rdata (rdata)
    );

    assign pos_x = EXT_W'(r_pos);
    assign idx_x = EXT_W'(r_idx);
    assign cnt_x = EXT_W'(r_cnt);

    // rdata holds the entry addressed in the previous cycle
    assign sort_hit    = (r_val <= rdata);
    assign idx_next_lt = (idx_x + EXT_W'(1)) < cnt_x;

    always_comb begin
        o_flags.empty      = (r_cnt == '0);
        o_flags.full       = (r_cnt == CNT_W'(CAPACITY));
        o_flags.pos_gt_cnt = (pos_x > cnt_x);
        o_flags.pos_ge_cnt = (pos_x >= cnt_x);
        o_flags.cnt_le_pos = (cnt_x <= pos_x);
        o_flags.up_more    = (idx_x > pos_x + EXT_W'(1));
        o_flags.no_dn      = !((pos_x + EXT_W'(1)) < cnt_x);
        o_flags.dn_more    = (idx_x + EXT_W'(2)) < cnt_x;
        o_flags.sort_more  = !sort_hit && idx_next_lt;
        o_flags.find_more  = (rdata != r_val) && idx_next_lt;
    end

    always_comb begin
        n_val    = r_val;
        n_pos    = r_pos;
        n_idx    = r_idx;
        n_cnt    = r_cnt;
        n_data   = r_data;
        n_found  = r_found;
        n_status = r_status;
        we       = 1'b0;
        waddr_x  = pos_x;
        wdata    = r_val;
        raddr_x  = pos_x;

        if (i_ctrl.load) begin
            n_val    = i_req.value;
            n_pos    = PTR_W'(i_req.position);
            n_data   = '0;
            n_found  = 1'b0;
            n_status = ST_OK;
        end

        case (i_ctrl.op)
            OP_NOP, OP_EMIT: begin
            end
            OP_SET_RANGE: n_status = ST_RANGE;
            OP_SET_EMPTY: n_status = ST_EMPTY;
            OP_SET_FULL:  n_status = ST_FULL;
            OP_POS_ZERO:  n_pos = '0;
            OP_POS_CNT:   n_pos = PTR_W'(r_cnt);
            OP_POS_LAST:  n_pos = PTR_W'(r_cnt) - PTR_W'(1);
            OP_IDX_CNT: begin
                n_idx   = PTR_W'(r_cnt);
                raddr_x = cnt_x - EXT_W'(1);
            end
            OP_SHIFT_UP: begin
                // entry idx-1 arrives now, goes up one place
                we      = 1'b1;
                waddr_x = idx_x;
                wdata   = rdata;
                raddr_x = idx_x - EXT_W'(2);
                n_idx   = r_idx - PTR_W'(1);
            end
            OP_WR_VAL_INC: begin
                we      = 1'b1;
                waddr_x = pos_x;
                wdata   = r_val;
                n_cnt   = r_cnt + CNT_W'(1);
            end
            OP_IDX_POS: begin
                n_idx   = r_pos;
                raddr_x = pos_x + EXT_W'(1);
            end
            OP_SHIFT_DN: begin
                we      = 1'b1;
                waddr_x = idx_x;
                wdata   = rdata;
                raddr_x = idx_x + EXT_W'(2);
                n_idx   = r_idx + PTR_W'(1);
            end
            OP_DEC_CNT: n_cnt = r_cnt - CNT_W'(1);
            OP_WR_POS: begin
                we      = 1'b1;
                waddr_x = pos_x;
                wdata   = r_val;
            end
            OP_RD_POS:    raddr_x = pos_x;
            OP_LATCH:     n_data = rdata;
            OP_SCAN_START: begin
                n_idx   = '0;
                n_pos   = '0;
                raddr_x = '0;
            end
            OP_SCAN_SORT: begin
                n_pos   = sort_hit ? r_idx : r_idx + PTR_W'(1);
                n_idx   = r_idx + PTR_W'(1);
                raddr_x = idx_x + EXT_W'(1);
            end
            OP_SCAN_FIND: begin
                if (rdata == r_val) begin
                    n_found = 1'b1;
                end
                n_idx   = r_idx + PTR_W'(1);
                raddr_x = idx_x + EXT_W'(1);
            end
            OP_CLEAR:     n_cnt = '0;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val    <= n_val;
        r_pos    <= n_pos;
        r_idx    <= n_idx;
        r_data   <= n_data;
        r_found  <= n_found;
        r_status <= n_status;
    end

    assign o_res.data   = r_data;
    assign o_res.found  = r_found;
    assign o_res.count  = COUNT_W'(r_cnt);
    assign o_res.status = r_status;

endmodule

### hdl/indexed_char_sequence_buffer.sv
// channel    valid        stall        payload   dir
// request    i_req_valid  o_req_stall  i_req     in   (t_req: command, value, position)
// result     o_res_valid  i_res_stall  o_res     out  (t_res: data, found, count, status)
//
// One request at a time; o_req_stall stays high from acceptance until the sequencer has
// raised o_res_valid and returned to idle, and only then is the next request taken.
// Push front, insert, sorted insert, pop front, remove and find shift or scan one entry
// per cycle through the one-write, one-read store; push back and pop back shift nothing.
// Synchronous active-low reset empties the list; store contents are not cleared.
// A finished result waits in the output register; the next request is taken
// meanwhile and stalls only at its own result if that register is still full.
// Depends on icsb_pkg, icsb_seq, icsb_dp.
module indexed_char_sequence_buffer import icsb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_stall,
    input  t_req i_req,
    output logic o_res_valid,
    input  logic i_res_stall,
    output t_res o_res
);

    t_flags   flags;
    t_dp_ctrl ctrl;
    t_res     dp_res;
    logic     busy;
    logic     emit;
    logic     out_free;

    logic     r_res_valid;
    t_res     r_res;

    assign out_free = !r_res_valid || !i_res_stall;

    icsb_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_cmd       (i_req.command),
        .i_flags     (flags),
        .i_out_free  (out_free),
        .o_busy      (busy),
        .o_ctrl      (ctrl),
        .o_emit      (emit)
    );

    icsb_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl),
        .i_req   (i_req),
        .o_flags (flags),
        .o_res   (dp_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (emit) begin
            r_res_valid <= 1'b1;
        end else if (!i_res_stall) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_res <= dp_res;
        end
    end

    assign o_req_stall = busy;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule
